### sv/face_bounding_box_with_margin_core_macros.svh
`ifndef FACE_BOUNDING_BOX_WITH_MARGIN_CORE_MACROS_SVH
`define FACE_BOUNDING_BOX_WITH_MARGIN_CORE_MACROS_SVH

// check a same-cycle implication and a next-cycle implication
`ifndef NO_ASSERTIONS
`define FBBM_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("fbbm assertion failed");
`define FBBM_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("fbbm assertion failed");
`else
`define FBBM_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons)
`define FBBM_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif

`endif

### sv/fbbm_pkg.sv
package fbbm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int FACTOR_WIDTH    = 24;
    localparam int FRAC_BITS       = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int PADDR_WIDTH     = 3;
    localparam int PDATA_WIDTH     = 32;
    localparam int REG_IDX_LSB     = 2;

    localparam logic [0:0] REG_MARGIN_FACTOR = 1'b0;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] x_coord;
        logic signed [FIELD_WIDTH-1:0] y_coord;
        logic signed [FIELD_WIDTH-1:0] z_coord;
        logic                          last_vertex;
    } vtx_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] min_x;
        logic signed [FIELD_WIDTH-1:0] min_y;
        logic signed [FIELD_WIDTH-1:0] min_z;
        logic signed [FIELD_WIDTH-1:0] max_x;
        logic signed [FIELD_WIDTH-1:0] max_y;
        logic signed [FIELD_WIDTH-1:0] max_z;
    } box_t;

endpackage

### sv/fbbm_front.sv
module fbbm_front #(
    parameter int CW = fbbm_pkg::COORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vtx_valid,
    output logic             vtx_ready,
    input  fbbm_pkg::vtx_t   vtx,
    input  logic             full,
    output logic             push,
    output logic [6*CW-1:0]  push_box
);
    import fbbm_pkg::*;

    logic [FIELD_WIDTH-1:0] raw [3];
    logic signed [CW-1:0]   coord [3];
    logic signed [CW-1:0]   lo_reg [3];
    logic signed [CW-1:0]   hi_reg [3];
    logic signed [CW-1:0]   lo_next [3];
    logic signed [CW-1:0]   hi_next [3];
    logic                   face_start_reg;
    logic                   accept;

    assign raw[0] = vtx.x_coord;
    assign raw[1] = vtx.y_coord;
    assign raw[2] = vtx.z_coord;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        if (CW <= FIELD_WIDTH)
        begin : g_trunc
            assign coord[a] = raw[a][CW-1:0];
        end
        else
        begin : g_sext
            assign coord[a] = {{(CW-FIELD_WIDTH){raw[a][FIELD_WIDTH-1]}}, raw[a]};
        end
    end

    assign vtx_ready = !full;
    assign accept    = vtx_valid && vtx_ready;
    assign push      = accept && vtx.last_vertex;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            lo_next[a] = (face_start_reg || coord[a] < lo_reg[a]) ? coord[a] : lo_reg[a];
            hi_next[a] = (face_start_reg || coord[a] > hi_reg[a]) ? coord[a] : hi_reg[a];
            push_box[a*CW +: CW]     = lo_next[a];
            push_box[(3+a)*CW +: CW] = hi_next[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_reg[a] <= lo_next[a];
                hi_reg[a] <= hi_next[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_start_reg <= 1'b1;
        end
        else if (accept)
        begin
            face_start_reg <= vtx.last_vertex;
        end
    end

endmodule

### sv/fbbm_queue.sv
`include "face_bounding_box_with_margin_core_macros.svh"

module fbbm_queue #(
    parameter int WIDTH = 6 * fbbm_pkg::COORD_WIDTH_DEF,
    parameter int DEPTH = fbbm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             not_empty
);
    import fbbm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [NW-1:0]    count_next;

    assign rd_data   = mem_reg[rd_ptr_reg];
    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    `FBBM_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= NW'(DEPTH))
    `FBBM_ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, pop, count_reg != '0)
    `FBBM_ASSERT_IMPLIES(a_no_push_full, clk, rst_n, push, count_reg != NW'(DEPTH))

endmodule

### sv/fbbm_back.sv
`include "face_bounding_box_with_margin_core_macros.svh"

module fbbm_back #(
    parameter int CW = fbbm_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fbbm_pkg::FACTOR_WIDTH-1:0] margin_factor,
    input  logic                              q_valid,
    input  logic [6*CW-1:0]                   q_data,
    output logic                              pop,
    output logic                              box_valid,
    input  logic                              box_ready,
    output fbbm_pkg::box_t                    box
);
    import fbbm_pkg::*;

    localparam int HW       = (CW + 1) / 2;
    localparam int PLW      = HW + FACTOR_WIDTH;
    localparam int PHW      = CW - HW + FACTOR_WIDTH;
    localparam int SUM_W    = CW + FACTOR_WIDTH + 1;
    localparam int RAW_W    = SUM_W - FRAC_BITS;
    localparam int MARGIN_W = CW + 2;
    localparam int EXT_W    = CW + 3;
    localparam logic [RAW_W-1:0] CAP = RAW_W'(1) << (CW + 1);

    function automatic logic [CW-1:0] sat_coord(input logic [EXT_W-1:0] v);
        logic [CW-1:0] r;
        if (v[EXT_W-1] && (v[EXT_W-1:CW-1] != '1))
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else if (!v[EXT_W-1] && (v[EXT_W-1:CW-1] != '0))
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    logic                  advance;
    logic                  s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                  box_valid_reg;
    logic [6*CW-1:0]       s1_box_reg, s2_box_reg, s3_box_reg, s4_box_reg;
    logic [CW-1:0]         s1_span_reg [3];
    logic [CW-1:0]         s1_span_next [3];
    logic [CW-1:0]         s2_span_reg, s2_span_next;
    logic [PLW-1:0]        s3_plo_reg, s3_plo_next;
    logic [PHW-1:0]        s3_phi_reg, s3_phi_next;
    logic [SUM_W-1:0]      prod_full;
    logic [RAW_W-1:0]      margin_raw;
    logic [MARGIN_W-1:0]   s4_margin_reg, s4_margin_next;
    logic [CW-1:0]         res [6];
    logic [FIELD_WIDTH-1:0] field [6];
    box_t                  box_reg, box_next;

    assign advance   = !box_valid_reg || box_ready;
    assign pop       = advance && q_valid;
    assign box_valid = box_valid_reg;
    assign box       = box_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s1_span_next[a] = q_data[(3+a)*CW +: CW] - q_data[a*CW +: CW];
        end
    end

    always_comb
    begin
        s2_span_next = s1_span_reg[0];
        if (s1_span_reg[1] > s2_span_next)
        begin
            s2_span_next = s1_span_reg[1];
        end
        if (s1_span_reg[2] > s2_span_next)
        begin
            s2_span_next = s1_span_reg[2];
        end
    end

    assign s3_plo_next = PLW'(s2_span_reg[HW-1:0]) * PLW'(margin_factor);
    assign s3_phi_next = PHW'(s2_span_reg[CW-1:HW]) * PHW'(margin_factor);

    assign prod_full      = (SUM_W'(s3_phi_reg) << HW) + SUM_W'(s3_plo_reg);
    assign margin_raw     = prod_full[SUM_W-1:FRAC_BITS];
    assign s4_margin_next = (margin_raw > CAP) ? MARGIN_W'(CAP) : MARGIN_W'(margin_raw);

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            res[a]   = sat_coord(EXT_W'($signed(s4_box_reg[a*CW +: CW]))
                                 - EXT_W'(s4_margin_reg));
            res[3+a] = sat_coord(EXT_W'($signed(s4_box_reg[(3+a)*CW +: CW]))
                                 + EXT_W'(s4_margin_reg));
        end
    end

    for (genvar i = 0; i < 6; i++)
    begin : g_field
        if (CW >= FIELD_WIDTH)
        begin : g_cut
            assign field[i] = res[i][FIELD_WIDTH-1:0];
        end
        else
        begin : g_zext
            assign field[i] = {{(FIELD_WIDTH-CW){1'b0}}, res[i]};
        end
    end

    always_comb
    begin
        box_next.min_x = field[0];
        box_next.min_y = field[1];
        box_next.min_z = field[2];
        box_next.max_x = field[3];
        box_next.max_y = field[4];
        box_next.max_z = field[5];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_box_reg    <= q_data;
            s1_span_reg   <= s1_span_next;
            s2_box_reg    <= s1_box_reg;
            s2_span_reg   <= s2_span_next;
            s3_box_reg    <= s2_box_reg;
            s3_plo_reg    <= s3_plo_next;
            s3_phi_reg    <= s3_phi_next;
            s4_box_reg    <= s3_box_reg;
            s4_margin_reg <= s4_margin_next;
            box_reg       <= box_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            box_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            box_valid_reg <= s4_valid_reg;
        end
    end

    `FBBM_ASSERT_IMPLIES(a_margin_capped, clk, rst_n, s4_valid_reg,
                         s4_margin_reg <= MARGIN_W'(CAP))
    `FBBM_ASSERT_NEXT(a_stage4_reaches_out, clk, rst_n, s4_valid_reg && advance,
                      box_valid_reg)

endmodule

### sv/face_bounding_box_with_margin_core.sv
// Face bounding box with relative margin.
// Vertex channel (vtx_valid/vtx_ready/vtx): one vertex per transaction, x, y, z
// in signed Q16.16 and last_vertex set on the final vertex of a face.
// Box channel (box_valid/box_ready/box): one widened, saturated box per face.
// The margin is the largest axis span times margin_factor (unsigned Q8.16),
// subtracted from each lower bound and added to each upper bound.
// Configuration: APB write of margin_factor at byte address 0, pready tied
// high; write it only while no face is in flight.
// Throughput: one vertex per cycle while the box queue is not full; faces of any
// length, single-vertex faces included, sustain one box per cycle while box_ready is high.
// Path: after its last vertex is taken, the box of a face passes in turn through the
// queue hop, span, max span, split multiply, margin sum and saturation registers.
// Stall: when box_ready is low while box_valid is high the back pipeline holds; the four-entry box queue
// absorbs faces until full, and only then vtx_ready drops.
// Reset: clears the queue, pipeline valids and margin_factor, and arms the
// front so the next vertex starts a new face.
module face_bounding_box_with_margin_core #(
    parameter int COORD_WIDTH = fbbm_pkg::COORD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vtx_valid,
    output logic                             vtx_ready,
    input  fbbm_pkg::vtx_t                   vtx,
    output logic                             box_valid,
    input  logic                             box_ready,
    output fbbm_pkg::box_t                   box,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fbbm_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [fbbm_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [fbbm_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                             pready
);
    import fbbm_pkg::*;

    localparam int BOX_W = 6 * COORD_WIDTH;

    logic [FACTOR_WIDTH-1:0] margin_factor_reg;
    logic [0:0]              reg_idx;
    logic                    cfg_write;
    logic                    push;
    logic [BOX_W-1:0]        push_box;
    logic                    pop;
    logic [BOX_W-1:0]        q_data;
    logic                    q_full;
    logic                    q_valid;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[REG_IDX_LSB +: 1];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx == REG_MARGIN_FACTOR) ?
                       PDATA_WIDTH'(margin_factor_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_factor_reg <= '0;
        end
        else if (cfg_write && reg_idx == REG_MARGIN_FACTOR)
        begin
            margin_factor_reg <= pwdata[FACTOR_WIDTH-1:0];
        end
    end

    fbbm_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_ready (vtx_ready),
        .vtx       (vtx),
        .full      (q_full),
        .push      (push),
        .push_box  (push_box)
    );

    fbbm_queue #(
        .WIDTH (BOX_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (push_box),
        .pop       (pop),
        .rd_data   (q_data),
        .full      (q_full),
        .not_empty (q_valid)
    );

    fbbm_back #(
        .CW (COORD_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .margin_factor (margin_factor_reg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .box_valid     (box_valid),
        .box_ready     (box_ready),
        .box           (box)
    );

endmodule
